// File: rtl/prqs_pkg.sv
// Types and codes shared by the ready-queue scheduler.
package prqs_pkg;

    localparam int THREAD_ID_W = 5;
    localparam int PRIO_W      = 5;
    localparam int MAP_W       = 32;

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_SCHEDULE = 2'd2,
        KIND_START    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK            = 2'd0,
        STATUS_ALREADY_READY = 2'd1,
        STATUS_NOT_READY     = 2'd2,
        STATUS_NOTHING_READY = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                   kind;
        logic [THREAD_ID_W-1:0]  thread_id;
        logic [PRIO_W-1:0]       priority_req;
    } cmd_t;

    typedef struct packed {
        status_t                 status;
        logic                    switch_needed;
        logic [THREAD_ID_W-1:0]  next_thread;
        logic [PRIO_W-1:0]       next_priority;
        logic [THREAD_ID_W-1:0]  prev_thread;
        logic                    prev_valid;
        logic [MAP_W-1:0]        ready_map;
    } result_t;

endpackage

// File: rtl/priority_ready_queue_scheduler.sv
// Priority ready-queue scheduler: per-level FIFO lists of threads and a ready bitmap.
// An accepted item is registered, processed in one pass and its result is registered.
// Throughput: one item per cycle unless the receiver stalls, set by the single pass
// through the list tables and the find-first-set over the ready bitmap.
// Reset (rst_n, asynchronous, active low): bitmap and ready flags clear, no current
// thread, current priority the lowest level; list and link tables are not cleared.
module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int NUM_LEVELS  = 32,
    parameter int NUM_THREADS = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    // Thread numbers above the id field's range can never be named.
    localparam int THR_DEPTH = (NUM_THREADS < (2 ** THREAD_ID_W)) ? NUM_THREADS
                                                                  : (2 ** THREAD_ID_W);
    localparam int TW = $clog2(THR_DEPTH);
    localparam int LW = $clog2(NUM_LEVELS);

    // Input and result registers
    logic                   stage_valid_reg;
    cmd_t                   stage_reg;
    logic                   result_valid_reg;
    result_t                result_reg;
    logic                   advance;

    // Scheduler state
    logic [NUM_LEVELS-1:0]  ready_bits_reg, ready_bits_next;
    logic [THR_DEPTH-1:0]   thread_ready_reg, thread_ready_next;
    logic [TW-1:0]          running_thread_reg, running_thread_next;
    logic                   running_valid_reg, running_valid_next;
    logic [LW-1:0]          running_level_reg, running_level_next;

    logic [TW-1:0]          list_head_reg     [NUM_LEVELS];
    logic [TW-1:0]          list_tail_reg     [NUM_LEVELS];
    logic [TW-1:0]          link_next_reg     [THR_DEPTH];
    logic [TW-1:0]          link_prev_reg     [THR_DEPTH];
    logic                   link_has_next_reg [THR_DEPTH];
    logic                   link_has_prev_reg [THR_DEPTH];
    logic [LW-1:0]          thread_level_reg  [THR_DEPTH];

    // Decode
    logic                   tid_ok;
    logic [TW-1:0]          tid;
    logic [LW-1:0]          prio;
    logic                   do_insert;
    logic                   do_remove;
    logic                   insert_busy;
    logic [TW-1:0]          insert_last;
    logic [LW-1:0]          rem_level;
    logic [TW-1:0]          rem_prev;
    logic [TW-1:0]          rem_next;
    logic                   rem_has_prev;
    logic                   rem_has_next;
    logic [LW-1:0]          pick_level;
    logic [TW-1:0]          pick_thread;
    result_t                result_next;

    assign advance      = stage_valid_reg && (!result_valid_reg || result_ready);
    assign cmd_ready    = !stage_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        tid_ok       = (32'(stage_reg.thread_id) < NUM_THREADS);
        tid          = stage_reg.thread_id[TW-1:0];
        prio         = (32'(stage_reg.priority_req) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                                  : stage_reg.priority_req[LW-1:0];
        insert_busy  = ready_bits_reg[prio];
        insert_last  = list_tail_reg[prio];
        rem_level    = thread_level_reg[tid];
        rem_prev     = link_prev_reg[tid];
        rem_next     = link_next_reg[tid];
        rem_has_prev = link_has_prev_reg[tid];
        rem_has_next = link_has_next_reg[tid];

        // Find the highest-priority (lowest-numbered) non-empty level
        pick_level = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (ready_bits_reg[i])
            begin
                pick_level = LW'(i);
            end
        end
        pick_thread = list_head_reg[pick_level];

        do_insert           = 1'b0;
        do_remove           = 1'b0;
        ready_bits_next     = ready_bits_reg;
        thread_ready_next   = thread_ready_reg;
        running_thread_next = running_thread_reg;
        running_valid_next  = running_valid_reg;
        running_level_next  = running_level_reg;

        result_next               = '0;
        result_next.status        = STATUS_OK;

        case (stage_reg.kind)
            KIND_INSERT:
            begin
                if (!tid_ok)
                begin
                    result_next.status = STATUS_NOT_READY;
                end
                else if (thread_ready_reg[tid])
                begin
                    result_next.status = STATUS_ALREADY_READY;
                end
                else
                begin
                    do_insert               = 1'b1;
                    thread_ready_next[tid]  = 1'b1;
                    ready_bits_next[prio]   = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (!tid_ok || !thread_ready_reg[tid])
                begin
                    result_next.status = STATUS_NOT_READY;
                end
                else
                begin
                    do_remove              = 1'b1;
                    thread_ready_next[tid] = 1'b0;
                    // Drop the level bit only when its list empties
                    if (!rem_has_prev && !rem_has_next)
                    begin
                        ready_bits_next[rem_level] = 1'b0;
                    end
                end
            end
            default:
            begin
                if (ready_bits_reg == '0)
                begin
                    result_next.status = STATUS_NOTHING_READY;
                end
                else
                begin
                    if (!running_valid_reg || (running_thread_reg != pick_thread))
                    begin
                        result_next.switch_needed = 1'b1;
                        if (running_valid_reg)
                        begin
                            result_next.prev_thread = THREAD_ID_W'(running_thread_reg);
                            result_next.prev_valid  = 1'b1;
                        end
                    end
                    running_thread_next = pick_thread;
                    running_valid_next  = 1'b1;
                    running_level_next  = pick_level;
                end
            end
        endcase

        result_next.next_thread   = running_valid_next ? THREAD_ID_W'(running_thread_next)
                                                       : '0;
        result_next.next_priority = PRIO_W'(running_level_next);
        result_next.ready_map     = MAP_W'(ready_bits_next);
    end

    // Control and resettable state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg    <= 1'b0;
            result_valid_reg   <= 1'b0;
            ready_bits_reg     <= '0;
            thread_ready_reg   <= '0;
            running_thread_reg <= '0;
            running_valid_reg  <= 1'b0;
            running_level_reg  <= LW'(NUM_LEVELS - 1);
        end
        else
        begin
            if (cmd_ready)
            begin
                stage_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                result_valid_reg   <= 1'b1;
                ready_bits_reg     <= ready_bits_next;
                thread_ready_reg   <= thread_ready_next;
                running_thread_reg <= running_thread_next;
                running_valid_reg  <= running_valid_next;
                running_level_reg  <= running_level_next;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and list tables
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            stage_reg <= cmd;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
        if (advance && do_insert)
        begin
            if (insert_busy)
            begin
                // Append behind the current tail
                link_next_reg[insert_last]     <= tid;
                link_has_next_reg[insert_last] <= 1'b1;
                link_prev_reg[tid]             <= insert_last;
                link_has_prev_reg[tid]         <= 1'b1;
            end
            else
            begin
                list_head_reg[prio]    <= tid;
                link_prev_reg[tid]     <= '0;
                link_has_prev_reg[tid] <= 1'b0;
            end
            list_tail_reg[prio]    <= tid;
            link_next_reg[tid]     <= '0;
            link_has_next_reg[tid] <= 1'b0;
            thread_level_reg[tid]  <= prio;
        end
        if (advance && do_remove)
        begin
            // Unlink the thread from its neighbours
            if (rem_has_prev)
            begin
                link_next_reg[rem_prev]     <= rem_next;
                link_has_next_reg[rem_prev] <= rem_has_next;
            end
            else
            begin
                list_head_reg[rem_level] <= rem_next;
            end
            if (rem_has_next)
            begin
                link_prev_reg[rem_next]     <= rem_prev;
                link_has_prev_reg[rem_next] <= rem_has_prev;
            end
            else
            begin
                list_tail_reg[rem_level] <= rem_prev;
            end
        end
    end

    // A level is ready exactly while some thread is ready
    a_map_matches_threads: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_bits_reg == '0) == (thread_ready_reg == '0))
        else $error("ready bitmap disagrees with thread ready flags");

    a_running_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        running_valid_reg |=> running_valid_reg)
        else $error("current thread lost");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !advance) |=> (stage_valid_reg && $stable(stage_reg)))
        else $error("stalled item not held in input register");

    a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.switch_needed) |-> (result_reg.status == STATUS_OK))
        else $error("switch reported with error status");

endmodule

// File: sim/ready_queue_checker.sv
// Checker for the ready-queue scheduler: predicts each result and compares it field by field.
`timescale 1ns / 1ps

module ready_queue_checker
    import prqs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  logic    cmd_ready,
    input  cmd_t    cmd,
    input  logic    result_valid,
    input  logic    result_ready,
    input  result_t result,
    output int      fail_count,
    output int      pending
);

    // Shadow of the scheduler's state
    logic [MAP_W-1:0]       level_map;
    logic [THREAD_ID_W-1:0] level_head   [32];
    logic [THREAD_ID_W-1:0] level_tail   [32];
    logic [THREAD_ID_W-1:0] fwd_link     [32];
    logic [THREAD_ID_W-1:0] back_link    [32];
    bit                     has_fwd      [32];
    bit                     has_back     [32];
    logic [PRIO_W-1:0]      level_of     [32];
    bit                     on_list      [32];
    logic [THREAD_ID_W-1:0] run_thread;
    bit                     run_valid;
    logic [PRIO_W-1:0]      run_level;

    result_t sched_result_q[$];
    int      mismatch_count = 0;
    int      queued_count = 0;

    assign fail_count = mismatch_count;
    assign pending    = queued_count;

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endfunction

    // Apply one command to the shadow state and return the result it should produce
    function automatic result_t apply_sched_cmd(cmd_t c);
        result_t                r;
        logic [THREAD_ID_W-1:0] t;
        logic [THREAD_ID_W-1:0] pv;
        logic [THREAD_ID_W-1:0] nx;
        logic [PRIO_W-1:0]      lv;
        r = '0;
        t = c.thread_id;
        r.status = STATUS_OK;
        case (c.kind)
            KIND_INSERT:
            begin
                if (on_list[t]) begin
                    r.status = STATUS_ALREADY_READY;
                end
                else begin
                    lv = c.priority_req;
                    if (level_map[lv]) begin
                        fwd_link[level_tail[lv]] = t;
                        has_fwd[level_tail[lv]]  = 1'b1;
                        back_link[t]             = level_tail[lv];
                        has_back[t]              = 1'b1;
                    end
                    else begin
                        level_head[lv] = t;
                        back_link[t]   = '0;
                        has_back[t]    = 1'b0;
                    end
                    level_tail[lv] = t;
                    fwd_link[t]    = '0;
                    has_fwd[t]     = 1'b0;
                    level_of[t]    = lv;
                    on_list[t]     = 1'b1;
                    level_map[lv]  = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (!on_list[t]) begin
                    r.status = STATUS_NOT_READY;
                end
                else begin
                    lv = level_of[t];
                    pv = back_link[t];
                    nx = fwd_link[t];
                    if (has_back[t]) begin
                        fwd_link[pv] = nx;
                        has_fwd[pv]  = has_fwd[t];
                    end
                    else begin
                        level_head[lv] = nx;
                    end
                    if (has_fwd[t]) begin
                        back_link[nx] = pv;
                        has_back[nx]  = has_back[t];
                    end
                    else begin
                        level_tail[lv] = pv;
                    end
                    // clear the level only once its list is empty
                    if (!has_back[t] && !has_fwd[t])
                        level_map[lv] = 1'b0;
                    on_list[t] = 1'b0;
                end
            end
            default:
            begin
                if (level_map == '0) begin
                    r.status = STATUS_NOTHING_READY;
                end
                else begin
                    lv = '0;
                    for (int i = 31; i >= 0; i--)
                        if (level_map[i])
                            lv = PRIO_W'(i);
                    if (!run_valid || run_thread != level_head[lv]) begin
                        r.switch_needed = 1'b1;
                        if (run_valid) begin
                            r.prev_thread = run_thread;
                            r.prev_valid  = 1'b1;
                        end
                    end
                    run_thread = level_head[lv];
                    run_valid  = 1'b1;
                    run_level  = lv;
                end
            end
        endcase
        r.next_thread   = run_valid ? run_thread : '0;
        r.next_priority = run_level;
        r.ready_map     = level_map;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            level_map  = '0;
            run_thread = '0;
            run_valid  = 1'b0;
            run_level  = PRIO_W'(31);
            for (int i = 0; i < 32; i++) begin
                level_head[i] = '0;
                level_tail[i] = '0;
                fwd_link[i]   = '0;
                back_link[i]  = '0;
                has_fwd[i]    = 1'b0;
                has_back[i]   = 1'b0;
                level_of[i]   = '0;
                on_list[i]    = 1'b0;
            end
            sched_result_q.delete();
            queued_count = 0;
        end
        else begin
            if (result_valid && result_ready) begin
                if (sched_result_q.size() == 0) begin
                    $display("%0t ns: result with nothing expected, expected none, actual %h",
                             $time, result);
                    mismatch_count++;
                end
                else begin
                    want = sched_result_q.pop_front();
                    check_field("status", 32'(want.status), 32'(result.status));
                    check_field("switch_needed", 32'(want.switch_needed),
                                32'(result.switch_needed));
                    check_field("next_thread", 32'(want.next_thread), 32'(result.next_thread));
                    check_field("next_priority", 32'(want.next_priority),
                                32'(result.next_priority));
                    check_field("prev_thread", 32'(want.prev_thread), 32'(result.prev_thread));
                    check_field("prev_valid", 32'(want.prev_valid), 32'(result.prev_valid));
                    check_field("ready_map", want.ready_map, result.ready_map);
                end
            end
            if (cmd_valid && cmd_ready)
                sched_result_q.push_back(apply_sched_cmd(cmd));
            queued_count = sched_result_q.size();
        end
    end

endmodule

// File: sim/tb_top.sv
// Testbench top for the ready-queue scheduler: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
    import prqs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic    clk;
    logic    rst_n;
    logic    cmd_valid;
    logic    cmd_ready;
    cmd_t    cmd;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    int      fail_count;
    int      pending;

    int      cycle_count = 0;
    bit      quiet;
    bit      thread_queued[32];

    priority_ready_queue_scheduler i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    ready_queue_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_cmd(input kind_t op, input logic [4:0] tid, input logic [4:0] prio);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= '{kind: op, thread_id: tid, priority_req: prio};
        do @(posedge clk); while (!cmd_ready);
        @(negedge clk);
        if (op == KIND_INSERT)
            thread_queued[tid] = 1'b1;
        else if (op == KIND_REMOVE)
            thread_queued[tid] = 1'b0;
    endtask

    // Mostly pick a thread whose ready state suits the operation
    function automatic logic [4:0] pick_thread(bit want_queued);
        logic [4:0] t;
        t = 5'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 85)
            for (int i = 0; i < 16 && thread_queued[t] != want_queued; i++)
                t = 5'($urandom_range(0, 31));
        return t;
    endfunction

    // Receiver: random stalls, stretches without stalls, and one long hold
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (taken == 400)
                stall = 200;
            else if (((taken / 110) % 3) == 2)
                stall = 0;
            else
                stall = $urandom_range(0, 15);
            if (stall > 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        kind_t      op;
        logic [4:0] tid;
        logic [4:0] prio;
        int         sel;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        quiet     = 1'b0;
        for (int i = 0; i < 32; i++)
            thread_queued[i] = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty bitmap, remove of an idle thread, duplicate insert
        send_cmd(KIND_SCHEDULE, 5'd9, 5'd4);
        send_cmd(KIND_START, 5'd31, 5'd31);
        send_cmd(KIND_REMOVE, 5'd5, 5'd0);
        send_cmd(KIND_INSERT, 5'd31, 5'd31);
        send_cmd(KIND_INSERT, 5'd0, 5'd31);
        send_cmd(KIND_INSERT, 5'd31, 5'd0);
        // First pick with no current thread, then a pick of the same thread
        send_cmd(KIND_START, 5'd0, 5'd0);
        send_cmd(KIND_SCHEDULE, 5'd0, 5'd0);
        send_cmd(KIND_INSERT, 5'd10, 5'd0);
        send_cmd(KIND_INSERT, 5'd21, 5'd0);
        send_cmd(KIND_INSERT, 5'd7, 5'd16);
        send_cmd(KIND_SCHEDULE, 5'd0, 5'd0);
        // Remove the running thread, then unlink head, middle and tail
        send_cmd(KIND_REMOVE, 5'd10, 5'd0);
        send_cmd(KIND_SCHEDULE, 5'd0, 5'd0);
        send_cmd(KIND_INSERT, 5'd10, 5'd0);
        send_cmd(KIND_INSERT, 5'd3, 5'd0);
        send_cmd(KIND_REMOVE, 5'd10, 5'd0);
        send_cmd(KIND_REMOVE, 5'd3, 5'd0);
        send_cmd(KIND_REMOVE, 5'd21, 5'd0);
        send_cmd(KIND_START, 5'd0, 5'd0);
        send_cmd(KIND_REMOVE, 5'd7, 5'd0);
        send_cmd(KIND_REMOVE, 5'd31, 5'd0);
        send_cmd(KIND_REMOVE, 5'd0, 5'd0);
        send_cmd(KIND_SCHEDULE, 5'd0, 5'd0);
        send_cmd(KIND_START, 5'd0, 5'd0);

        for (int n = 0; n < 850; n++) begin
            quiet = ((n / 90) % 3) == 1;
            sel = $urandom_range(0, 99);
            if (sel < 42)
                op = KIND_INSERT;
            else if (sel < 72)
                op = KIND_REMOVE;
            else if (sel < 90)
                op = KIND_SCHEDULE;
            else
                op = KIND_START;
            if (op == KIND_INSERT || op == KIND_REMOVE)
                tid = pick_thread(op == KIND_REMOVE);
            else
                tid = 5'($urandom_range(0, 31));
            // crowd a few levels so lists grow long
            prio = $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
            send_cmd(op, tid, prio);
        end
        cmd_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
